FILE: hw/rtl/assert_macros.svh
// Assertion macros for the checker file of the stepper block.
// Each macro expects signals named clk and arst_n in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication that holds in the same cycle.
`define MABS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that a condition leads to a consequence in the next cycle.
`define MABS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/mabs_pkg.sv
// Package for the multi-axis Bresenham stepper: sizes, controller states and
// the command and status bundles between controller and datapath. No dependencies.
package mabs_pkg;

	localparam int NUM_AXES = 3;
	localparam int POS_BITS = 16;
	localparam int FIELD_BITS = 16;
	localparam int IDX_BITS = 3;
	localparam int MASK_W = 8;
	localparam int AXIS_W = $clog2(NUM_AXES);
	localparam int ERR_W = POS_BITS + 3;
	localparam int SUM_W = ERR_W + 2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_SEL,
		ST_SETUP,
		ST_TREF,
		ST_TERR,
		ST_DONE
	} mabs_state_t;

	typedef struct packed {
		logic capture;
		logic load_wr;
		logic sel_step;
		logic setup_step;
		logic tref;
		logic terr_step;
		logic cnt_clr;
		logic push;
	} mabs_cmd_t;

	typedef struct packed {
		logic last;
		logic stop;
		logic cnt_last;
	} mabs_stat_t;

endpackage

FILE: hw/rtl/mabs_ctrl.sv
// Controller of the stepper: sequences load, reference selection, error setup
// and tick walks, and owns both handshakes. Depends on mabs_pkg.
module mabs_ctrl import mabs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       cmd,
	output logic       out_valid,
	input  logic       out_ready,
	input  mabs_stat_t sts,
	output mabs_cmd_t  ctl
);

	mabs_state_t state_q, state_d;
	logic        out_valid_q;
	logic        slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.push)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d  = state_q;
		ctl      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.capture = 1'b1;
					state_d     = cmd ? ST_TREF : ST_LOAD;
				end
			end
			ST_LOAD: begin
				ctl.load_wr = 1'b1;
				state_d     = sts.last ? ST_SEL : ST_DONE;
			end
			ST_SEL: begin
				ctl.sel_step = 1'b1;
				if (sts.cnt_last) begin
					ctl.cnt_clr = 1'b1;
					state_d     = ST_SETUP;
				end
			end
			ST_SETUP: begin
				ctl.setup_step = 1'b1;
				if (sts.cnt_last)
					state_d = ST_DONE;
			end
			ST_TREF: begin
				ctl.tref = 1'b1;
				state_d  = ST_TERR;
			end
			ST_TERR: begin
				// skip the walk once the reference axis has finished
				if (sts.stop)
					state_d = ST_DONE;
				else begin
					ctl.terr_step = 1'b1;
					if (sts.cnt_last)
						state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (slot_free) begin
					ctl.push = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

FILE: hw/rtl/mabs_dp.sv
// Datapath of the stepper: per-axis position, end, delta and error registers,
// the axis walk counter and the result register. Depends on mabs_pkg.
module mabs_dp import mabs_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [IDX_BITS-1:0]   axis_index,
	input  logic [FIELD_BITS-1:0] start_pos,
	input  logic [FIELD_BITS-1:0] end_pos,
	input  logic                  last_axis,
	input  mabs_cmd_t             ctl,
	output mabs_stat_t            sts,
	output logic [MASK_W-1:0]     step_mask,
	output logic                  segment_done,
	output logic [IDX_BITS-1:0]   reference_axis,
	output logic                  bad_segment
);

	localparam logic [ERR_W-1:0] ERR_MAX = {1'b0, {(ERR_W-1){1'b1}}};
	localparam logic [ERR_W-1:0] ERR_MIN = {1'b1, {(ERR_W-1){1'b0}}};

	// captured request
	logic [IDX_BITS-1:0] axis_q;
	logic [POS_BITS-1:0] start_q, end_q;
	logic                last_q;

	// axis state
	logic [POS_BITS:0]   pos_q   [NUM_AXES];
	logic [POS_BITS-1:0] end_a_q [NUM_AXES];
	logic [POS_BITS-1:0] delta_q [NUM_AXES];
	logic [ERR_W-1:0]    err_q   [NUM_AXES];
	logic [AXIS_W-1:0]   ref_idx_q;
	logic [POS_BITS-1:0] ref_delta_q;
	logic                bad_q;
	logic [AXIS_W-1:0]   cnt_q;

	logic [MASK_W-1:0]   mask_q;
	logic                done_q;

	logic [MASK_W-1:0]   step_mask_q;
	logic                segment_done_q;
	logic [IDX_BITS-1:0] reference_axis_q;
	logic                bad_segment_q;

	logic [POS_BITS-1:0] cur_delta;
	logic [ERR_W-1:0]    cur_err;
	logic [POS_BITS:0]   ref_pos;
	logic [POS_BITS-1:0] ref_end;
	logic                pos_lt, pos_le;
	logic [SUM_W-1:0]    err_ext, dbl_delta, dbl_ref, ref_ext, tick_sum, setup_sum;
	logic                err_step, sel_better, ld_in_range, ld_rev, is_ref;
	logic [AXIS_W-1:0]   ld_idx;
	logic                walk_step;

	function automatic logic [ERR_W-1:0] sat_err(input logic [SUM_W-1:0] x);
		logic [SUM_W-ERR_W:0] top;
		begin
			top = x[SUM_W-1:ERR_W-1];
			if (top == '0 || top == '1)
				sat_err = x[ERR_W-1:0];
			else
				sat_err = x[SUM_W-1] ? ERR_MIN : ERR_MAX;
		end
	endfunction

	assign cur_delta = delta_q[cnt_q];
	assign cur_err   = err_q[cnt_q];
	assign ref_pos   = pos_q[ref_idx_q];
	assign ref_end   = end_a_q[ref_idx_q];
	assign pos_lt    = ref_pos < {1'b0, ref_end};
	assign pos_le    = ref_pos <= {1'b0, ref_end};
	assign is_ref    = cnt_q == ref_idx_q;

	assign err_ext   = {{(SUM_W-ERR_W){cur_err[ERR_W-1]}}, cur_err};
	assign dbl_delta = {{(SUM_W-POS_BITS-1){1'b0}}, cur_delta, 1'b0};
	assign dbl_ref   = {{(SUM_W-POS_BITS-1){1'b0}}, ref_delta_q, 1'b0};
	assign ref_ext   = {{(SUM_W-POS_BITS){1'b0}}, ref_delta_q};
	assign err_step  = !cur_err[ERR_W-1];
	assign tick_sum  = err_ext + dbl_delta - (err_step ? dbl_ref : '0);
	assign setup_sum = dbl_delta - ref_ext;

	assign sel_better  = (cnt_q == '0) || (cur_delta > ref_delta_q);
	assign ld_in_range = {1'b0, axis_q} < (IDX_BITS+1)'(NUM_AXES);
	assign ld_idx      = axis_q[AXIS_W-1:0];
	assign ld_rev      = end_q < start_q;
	assign walk_step   = ctl.sel_step || ctl.setup_step || ctl.terr_step;

	assign sts.last     = last_q;
	assign sts.stop     = done_q;
	assign sts.cnt_last = cnt_q == AXIS_W'(NUM_AXES - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_AXES; i++) begin
				pos_q[i]   <= '0;
				end_a_q[i] <= '0;
				delta_q[i] <= '0;
				err_q[i]   <= '0;
			end
			ref_idx_q   <= '0;
			ref_delta_q <= '0;
			bad_q       <= 1'b0;
			cnt_q       <= '0;
		end else begin
			if (ctl.capture || ctl.cnt_clr)
				cnt_q <= '0;
			else if (walk_step)
				cnt_q <= cnt_q + 1'b1;

			if (ctl.load_wr && ld_in_range) begin
				pos_q[ld_idx]   <= {1'b0, start_q};
				end_a_q[ld_idx] <= end_q;
				delta_q[ld_idx] <= ld_rev ? '0 : end_q - start_q;
				// axis 0 opens a new segment, so drop the old flag unless it is itself reversed
				if (ld_rev)
					bad_q <= 1'b1;
				else if (ld_idx == '0)
					bad_q <= 1'b0;
			end

			if (ctl.sel_step && sel_better) begin
				ref_idx_q   <= cnt_q;
				ref_delta_q <= cur_delta;
			end

			if (ctl.setup_step)
				err_q[cnt_q] <= is_ref ? '0 : sat_err(setup_sum);

			if (ctl.tref && pos_le)
				pos_q[ref_idx_q] <= ref_pos + 1'b1;

			if (ctl.terr_step && !is_ref)
				err_q[cnt_q] <= sat_err(tick_sum);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			axis_q  <= axis_index;
			start_q <= POS_BITS'(start_pos);
			end_q   <= POS_BITS'(end_pos);
			last_q  <= last_axis;
			mask_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			if (ctl.tref) begin
				done_q <= !pos_lt;
				if (pos_lt)
					mask_q[IDX_BITS'(ref_idx_q)] <= 1'b1;
			end
			if (ctl.terr_step && !is_ref && err_step)
				mask_q[IDX_BITS'(cnt_q)] <= 1'b1;
		end

		if (ctl.push) begin
			step_mask_q      <= mask_q;
			segment_done_q   <= done_q;
			reference_axis_q <= IDX_BITS'(ref_idx_q);
			bad_segment_q    <= bad_q;
		end
	end

	assign step_mask      = step_mask_q;
	assign segment_done   = segment_done_q;
	assign reference_axis = reference_axis_q;
	assign bad_segment    = bad_segment_q;

endmodule

FILE: hw/rtl/multi_axis_bresenham_stepper.sv
// Multi-axis Bresenham step generator. Each request either loads one axis's
// segment (cmd 0) or is one step tick (cmd 1), and yields exactly one result.
// A load marked last_axis then walks the axes once to pick the reference (the
// largest delta, lowest index on a tie) and walks them again to seed every
// other axis's error with 2*delta - ref_delta. A tick checks the reference axis
// and, unless it has reached its end, walks the other axes one per cycle to
// step them and update their errors. A new request is taken in the cycle
// after the result is parked in the output register, so a slow consumer
// costs nothing until a second result is ready. Reversed segments (end below
// start) raise bad_segment until the next load of axis 0 and move with zero
// delta. Loads addressed beyond the axis count write nothing but still run
// selection when marked last. Depends on mabs_pkg.
module multi_axis_bresenham_stepper import mabs_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  cmd,
	input  logic [IDX_BITS-1:0]   axis_index,
	input  logic [FIELD_BITS-1:0] start_pos,
	input  logic [FIELD_BITS-1:0] end_pos,
	input  logic                  last_axis,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [MASK_W-1:0]     step_mask,
	output logic                  segment_done,
	output logic [IDX_BITS-1:0]   reference_axis,
	output logic                  bad_segment
);

	mabs_cmd_t  ctl;
	mabs_stat_t sts;

	// sequencing and handshakes
	mabs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.ctl       (ctl)
	);

	// axis registers, shared error adder and result register
	mabs_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.axis_index     (axis_index),
		.start_pos      (start_pos),
		.end_pos        (end_pos),
		.last_axis      (last_axis),
		.ctl            (ctl),
		.sts            (sts),
		.step_mask      (step_mask),
		.segment_done   (segment_done),
		.reference_axis (reference_axis),
		.bad_segment    (bad_segment)
	);

endmodule

FILE: hw/rtl/mabs_checker.sv
// Port-level checker for the stepper, attached to the top level by bind.
// Depends on mabs_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mabs_checker import mabs_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic                  cmd,
	input logic [IDX_BITS-1:0]   axis_index,
	input logic [FIELD_BITS-1:0] start_pos,
	input logic [FIELD_BITS-1:0] end_pos,
	input logic                  last_axis,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [MASK_W-1:0]     step_mask,
	input logic                  segment_done,
	input logic [IDX_BITS-1:0]   reference_axis,
	input logic                  bad_segment
);

	`MABS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
	`MABS_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(step_mask) && $stable(segment_done) && $stable(reference_axis) && $stable(bad_segment), "stalled result changed")
	`MABS_ASSERT(a_done_no_step, out_valid && segment_done |-> step_mask == '0, "step issued on a finished segment")
	`MABS_ASSERT(a_ref_range, out_valid |-> {1'b0, reference_axis} < (IDX_BITS+1)'(NUM_AXES), "reference axis out of range")
	`MABS_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "request taken while busy")

endmodule

bind multi_axis_bresenham_stepper mabs_checker u_mabs_checker (.*);
